[sv/eac_pkg.sv]
// Package with codes, widths and transaction layouts for the encoder angle channel.
`default_nettype none

package eac_pkg;

	// Poll state codes.
	localparam logic [1:0] ST_VALID   = 2'd0;
	localparam logic [1:0] ST_NO_DATA = 2'd1;
	localparam logic [1:0] ST_UNAVAIL = 2'd2;
	localparam logic [1:0] ST_FAULT   = 2'd3;

	// Diagnostic codes.
	localparam logic [2:0] DG_NONE        = 3'd0;
	localparam logic [2:0] DG_REC_MISSING = 3'd1;
	localparam logic [2:0] DG_NOT_VALID   = 3'd2;
	localparam logic [2:0] DG_PROPAGATED  = 3'd3;
	localparam logic [2:0] DG_STALE       = 3'd4;
	localparam logic [2:0] DG_PAYLOAD     = 3'd5;

	// Configuration register indexes.
	localparam logic CFG_STALE_LIMIT = 1'b0;
	localparam logic CFG_ANGLE_PER_CNT = 1'b1;

	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [30:0] STALE_RESET_MS = 31'd250;

	localparam int unsigned IN_DATA_W  = 200;
	localparam int unsigned OUT_DATA_W = 200;

	// Input transaction, last field in the lowest bits.
	typedef struct packed {
		logic [2:0]         pad;
		logic signed [31:0] raw_count;
		logic               payload_ok;
		logic [31:0]        now_ms;
		logic [1:0]         source_health;
		logic [31:0]        source_restart_epoch;
		logic [31:0]        record_epoch;
		logic [63:0]        sample_sequence;
		logic               latest_present;
		logic               record_present;
	} in_item_t;

	// Result transaction, last field in the lowest bits.
	typedef struct packed {
		logic               pad;
		logic [32:0]        out_epoch;
		logic [63:0]        out_sequence;
		logic [31:0]        discontinuity_count;
		logic signed [63:0] angle;
		logic               published;
		logic [2:0]         diag_code;
		logic [1:0]         poll_state;
	} out_item_t;

endpackage

`default_nettype wire

[sv/encoder_angle_channel_with_health.sv]
// Top level of the encoder angle channel with source health classification.
// One poll enters per transaction on the slave side and gives exactly one
// result transaction on the master side. The block sustains one poll per clock
// cycle while the master side does not stall; an accepted poll is held in the
// input register and its result is then held in the result register. The
// throughput is set by the single classify and multiply-accumulate stage that
// also updates the channel state, so every poll sees the state left by the one
// before it. The input register keeps taking polls while a result waits on the
// master side, until both registers are full.
`default_nettype none

module encoder_angle_channel_with_health (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration write port.
	input  wire logic                              cfg_wr_en,
	input  wire logic                              cfg_index,
	input  wire logic [eac_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Poll input: record_present, latest_present, sample_sequence, record_epoch,
	// source_restart_epoch, source_health, now_ms, payload_ok, raw_count, zero pad.
	input  wire logic                              s_tvalid,
	output      logic                              s_tready,
	input  wire logic [eac_pkg::IN_DATA_W-1:0]     s_tdata,
	// Result output: poll_state, diag_code, published, angle, discontinuity_count,
	// out_sequence, out_epoch, zero pad.
	output      logic                              m_tvalid,
	input  wire logic                              m_tready,
	output      logic [eac_pkg::OUT_DATA_W-1:0]    m_tdata
);

	// Configuration registers.
	logic [30:0]        stale_limit_q;
	logic signed [31:0] angle_per_count_q;

	// Channel state.
	logic [63:0]        seen_sequence_q;
	logic [31:0]        seen_record_epoch_q;
	logic [31:0]        seen_source_epoch_q;
	logic               has_sample_q;
	logic [31:0]        last_sample_time_q;
	logic               have_baseline_q;
	logic [31:0]        baseline_count_q;
	logic signed [63:0] angle_acc_q;
	logic [31:0]        restart_count_q;

	// Pipeline registers.
	logic               valid_s1;
	eac_pkg::in_item_t  item_s1;
	logic               valid_s2;
	eac_pkg::out_item_t result_s2;

	logic               advance;

	// Combinational stage results.
	logic               is_new;
	logic               restart;
	logic               stale;
	logic [31:0]        elapsed;
	logic signed [31:0] delta;
	logic signed [63:0] step;
	logic signed [64:0] sum;
	logic signed [63:0] acc_next;
	logic               upd_seen;
	logic               upd_angle;
	logic               upd_restart;
	logic               upd_baseline;
	eac_pkg::out_item_t res_d;

	// The stage moves whenever the result register is empty or being drained.
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_limit_q     <= eac_pkg::STALE_RESET_MS;
			angle_per_count_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				eac_pkg::CFG_STALE_LIMIT:   stale_limit_q     <= cfg_data[30:0];
				eac_pkg::CFG_ANGLE_PER_CNT: angle_per_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= eac_pkg::in_item_t'(s_tdata);
		end
	end

	// Freshness tests and the angle step.
	always_comb begin
		is_new  = item_s1.latest_present &&
			(item_s1.sample_sequence != seen_sequence_q ||
			 item_s1.record_epoch != seen_record_epoch_q);
		restart = has_sample_q &&
			(item_s1.record_epoch != seen_record_epoch_q ||
			 item_s1.source_restart_epoch != seen_source_epoch_q);
		elapsed = item_s1.now_ms - last_sample_time_q;
		stale   = (stale_limit_q != '0) && has_sample_q &&
			(elapsed > {1'b0, stale_limit_q});
		delta   = item_s1.raw_count - $signed(baseline_count_q);
		step    = delta * angle_per_count_q;
		sum     = {angle_acc_q[63], angle_acc_q} + {step[63], step};
		// Saturate when the two top bits of the wide sum disagree.
		if (sum[64] != sum[63]) begin
			acc_next = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			acc_next = sum[63:0];
		end
	end

	// Classification in priority order and the result transaction.
	always_comb begin
		res_d        = '0;
		upd_seen     = 1'b0;
		upd_angle    = 1'b0;
		upd_restart  = 1'b0;
		upd_baseline = 1'b0;
		if (!item_s1.record_present) begin
			res_d.poll_state = eac_pkg::ST_FAULT;
			res_d.diag_code  = eac_pkg::DG_REC_MISSING;
		end else if (is_new) begin
			upd_seen = 1'b1;
			if (!item_s1.payload_ok) begin
				res_d.poll_state = eac_pkg::ST_FAULT;
				res_d.diag_code  = eac_pkg::DG_PAYLOAD;
			end else begin
				upd_baseline     = 1'b1;
				upd_restart      = restart;
				upd_angle        = !restart && have_baseline_q;
				res_d.poll_state = eac_pkg::ST_VALID;
				res_d.diag_code  = (item_s1.source_health != eac_pkg::ST_VALID) ?
					eac_pkg::DG_NOT_VALID : eac_pkg::DG_NONE;
				res_d.published  = 1'b1;
				res_d.angle      = upd_angle ? acc_next : angle_acc_q;
				res_d.discontinuity_count = restart ? restart_count_q + 32'd1 :
					restart_count_q;
				res_d.out_sequence = item_s1.sample_sequence;
				res_d.out_epoch    = {1'b0, item_s1.record_epoch} +
					{1'b0, item_s1.source_restart_epoch};
			end
		end else if (item_s1.source_health == eac_pkg::ST_UNAVAIL ||
				item_s1.source_health == eac_pkg::ST_FAULT) begin
			res_d.poll_state = item_s1.source_health;
			res_d.diag_code  = eac_pkg::DG_PROPAGATED;
		end else if (!item_s1.latest_present) begin
			res_d.poll_state = eac_pkg::ST_NO_DATA;
		end else if (stale) begin
			res_d.poll_state = eac_pkg::ST_UNAVAIL;
			res_d.diag_code  = eac_pkg::DG_STALE;
		end else begin
			res_d.poll_state = eac_pkg::ST_VALID;
		end
	end

	// State update, done as the poll leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_sequence_q     <= '0;
			seen_record_epoch_q <= '0;
			seen_source_epoch_q <= '0;
			has_sample_q        <= 1'b0;
			last_sample_time_q  <= '0;
			have_baseline_q     <= 1'b0;
			baseline_count_q    <= '0;
			angle_acc_q         <= '0;
			restart_count_q     <= '0;
		end else if (valid_s1 && advance) begin
			if (upd_seen) begin
				seen_sequence_q     <= item_s1.sample_sequence;
				seen_record_epoch_q <= item_s1.record_epoch;
				seen_source_epoch_q <= item_s1.source_restart_epoch;
				has_sample_q        <= 1'b1;
				last_sample_time_q  <= item_s1.now_ms;
			end
			if (upd_baseline) begin
				have_baseline_q  <= 1'b1;
				baseline_count_q <= item_s1.raw_count;
			end
			if (upd_angle) begin
				angle_acc_q <= acc_next;
			end
			if (upd_restart) begin
				restart_count_q <= restart_count_q + 32'd1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= res_d;
		end
	end

endmodule

`default_nettype wire

[sv/eac_checker.sv]
// Port-level checker for the encoder angle channel and its bind to the top level.
`default_nettype none

module eac_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [eac_pkg::OUT_DATA_W-1:0] m_tdata
);

	eac_pkg::out_item_t res;
	assign res = eac_pkg::out_item_t'(m_tdata);

	// A stalled result transaction holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Results that publish nothing carry zero sample fields.
	a_unpub_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.published |->
			res.angle == '0 && res.discontinuity_count == '0 &&
			res.out_sequence == '0 && res.out_epoch == '0)
		else $error("unpublished result carries sample fields");

	// A published sample is always reported valid.
	a_pub_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.published |->
			res.poll_state == eac_pkg::ST_VALID &&
			(res.diag_code == eac_pkg::DG_NONE ||
			 res.diag_code == eac_pkg::DG_NOT_VALID))
		else $error("published sample with bad state or diagnostic");

	// A missing record or a bad payload is always a fault.
	a_fault_diag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res.diag_code == eac_pkg::DG_REC_MISSING ||
			res.diag_code == eac_pkg::DG_PAYLOAD) |->
			res.poll_state == eac_pkg::ST_FAULT && !res.published)
		else $error("fault diagnostic without fault state");

	// A stale timeout reports the source as unavailable.
	a_stale: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.diag_code == eac_pkg::DG_STALE |->
			res.poll_state == eac_pkg::ST_UNAVAIL)
		else $error("stale diagnostic without unavailable state");

endmodule

bind encoder_angle_channel_with_health eac_checker u_eac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

[tb/encoder_angle_channel_with_health_tb.sv]
// Testbench for the encoder angle channel: directed and random polls checked against a predictor.

module encoder_angle_channel_with_health_tb;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic                           cfg_index;
	logic [eac_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           s_tvalid;
	logic                           s_tready;
	// Fields from bit 0 up: record_present, latest_present, sample_sequence, record_epoch,
	// source_restart_epoch, source_health, now_ms, payload_ok, raw_count, zero pad.
	logic [eac_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	// Fields from bit 0 up: poll_state, diag_code, published, angle, discontinuity_count,
	// out_sequence, out_epoch, zero pad.
	logic [eac_pkg::OUT_DATA_W-1:0] m_tdata;

	encoder_angle_channel_with_health dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Clock with a period of four units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Channel predictor: settings and tracking state, starting at their reset values.
	logic [30:0]        stale_limit  = eac_pkg::STALE_RESET_MS;
	logic signed [31:0] angle_step   = '0;
	logic [63:0]        last_seq     = '0;
	logic [31:0]        last_rec_ep  = '0;
	logic [31:0]        last_src_ep  = '0;
	logic               sample_seen  = 1'b0;
	logic [31:0]        sample_time  = '0;
	logic               baseline_ok  = 1'b0;
	logic [31:0]        baseline     = '0;
	longint             angle_sum    = 0;
	logic [31:0]        restarts     = '0;

	eac_pkg::out_item_t poll_results_q[$];
	int                 mismatches = 0;

	// Traffic shaping shared by the driver and the receiver.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_request = 0;
	int unsigned hold_left = 0;

	// Source model behind the random polls.
	logic [63:0]  src_seq;
	logic [31:0]  src_rec_ep;
	logic [31:0]  src_src_ep;
	logic [31:0]  src_now;
	logic [31:0]  src_count;
	int unsigned  count_span;

	// Work out the result of one accepted poll and queue it.
	task automatic predict_poll(input eac_pkg::in_item_t p);
		eac_pkg::out_item_t r;
		logic               restart;
		logic [31:0]        diff;
		logic [31:0]        elapsed;
		longint             prod;
		logic signed [64:0] wide;
		r = '0;
		if (!p.record_present) begin
			r.poll_state = eac_pkg::ST_FAULT;
			r.diag_code = eac_pkg::DG_REC_MISSING;
		end else if (p.latest_present &&
				(p.sample_sequence != last_seq || p.record_epoch != last_rec_ep)) begin
			restart = sample_seen && (p.record_epoch != last_rec_ep ||
				p.source_restart_epoch != last_src_ep);
			last_seq = p.sample_sequence;
			last_rec_ep = p.record_epoch;
			last_src_ep = p.source_restart_epoch;
			sample_seen = 1'b1;
			sample_time = p.now_ms;
			if (!p.payload_ok) begin
				r.poll_state = eac_pkg::ST_FAULT;
				r.diag_code = eac_pkg::DG_PAYLOAD;
			end else begin
				r.poll_state = eac_pkg::ST_VALID;
				r.diag_code = (p.source_health != eac_pkg::ST_VALID) ?
					eac_pkg::DG_NOT_VALID : eac_pkg::DG_NONE;
				if (restart) begin
					restarts = restarts + 32'd1;
				end else if (baseline_ok) begin
					// Wrapped count delta, scaled and added with saturation.
					diff = p.raw_count - baseline;
					prod = longint'(signed'(diff)) * longint'(angle_step);
					wide = 65'(angle_sum) + 65'(prod);
					if (wide[64] != wide[63])
						angle_sum = wide[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
					else
						angle_sum = wide[63:0];
				end
				baseline_ok = 1'b1;
				baseline = p.raw_count;
				r.published = 1'b1;
				r.angle = angle_sum;
				r.discontinuity_count = restarts;
				r.out_sequence = p.sample_sequence;
				r.out_epoch = {1'b0, p.record_epoch} + {1'b0, p.source_restart_epoch};
			end
		end else if (p.source_health == eac_pkg::ST_UNAVAIL ||
				p.source_health == eac_pkg::ST_FAULT) begin
			r.poll_state = p.source_health;
			r.diag_code = eac_pkg::DG_PROPAGATED;
		end else if (!p.latest_present) begin
			r.poll_state = eac_pkg::ST_NO_DATA;
		end else begin
			elapsed = p.now_ms - sample_time;
			if (stale_limit != 0 && sample_seen && elapsed > {1'b0, stale_limit}) begin
				r.poll_state = eac_pkg::ST_UNAVAIL;
				r.diag_code = eac_pkg::DG_STALE;
			end else begin
				r.poll_state = eac_pkg::ST_VALID;
			end
		end
		poll_results_q.push_back(r);
	endtask

	// Offer one poll, with random idle cycles first; returns at a falling edge.
	task automatic send_poll(input eac_pkg::in_item_t p);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_poll(p);
		@(negedge clk);
	endtask

	// Stop offering polls and wait until every predicted result has arrived.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (poll_results_q.size() != 0);
	endtask

	// Write both registers, one write per cycle; the block must be idle.
	task automatic load_settings(input logic [31:0] stale_word, input logic [31:0] step_word);
		cfg_wr_en <= 1'b1;
		cfg_index <= eac_pkg::CFG_STALE_LIMIT;
		cfg_data <= stale_word;
		@(negedge clk);
		cfg_index <= eac_pkg::CFG_ANGLE_PER_CNT;
		cfg_data <= step_word;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		stale_limit = stale_word[30:0];
		angle_step = step_word;
		@(negedge clk);
	endtask

	function automatic eac_pkg::in_item_t make_poll_item(input logic rec, input logic latest,
			input logic [63:0] seq, input logic [31:0] rec_ep, input logic [31:0] src_ep,
			input logic [1:0] health, input logic [31:0] now, input logic pay_ok,
			input logic [31:0] count);
		eac_pkg::in_item_t p;
		p = '0;
		p.record_present = rec;
		p.latest_present = latest;
		p.sample_sequence = seq;
		p.record_epoch = rec_ep;
		p.source_restart_epoch = src_ep;
		p.source_health = health;
		p.now_ms = now;
		p.payload_ok = pay_ok;
		p.raw_count = count;
		return p;
	endfunction

	// Next random poll: mostly a plausible source history, some pure noise.
	function automatic eac_pkg::in_item_t next_random_poll();
		eac_pkg::in_item_t p;
		int unsigned       roll;
		p = '0;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			p.record_present = 1'($urandom_range(0, 1));
			p.latest_present = 1'($urandom_range(0, 1));
			p.sample_sequence = {$urandom, $urandom};
			p.record_epoch = $urandom;
			p.source_restart_epoch = $urandom;
			p.source_health = 2'($urandom_range(0, 3));
			p.now_ms = $urandom;
			p.payload_ok = 1'($urandom_range(0, 1));
			p.raw_count = $urandom;
			return p;
		end
		// Time advances; now and then the source stays silent for a long time.
		if (roll < 11)
			src_now = src_now + $urandom;
		else if (roll < 16)
			src_now = src_now + $urandom_range(100, 600);
		else
			src_now = src_now + $urandom_range(0, 40);
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			// Upstream restart: one of the epochs moves on.
			if ($urandom_range(0, 1))
				src_src_ep = src_src_ep + 32'd1;
			else
				src_rec_ep = $urandom;
			if ($urandom_range(0, 1))
				src_seq = src_seq + 64'd1;
			src_count = $urandom;
		end else if (roll < 65) begin
			src_seq = src_seq + 64'd1;
			if ($urandom_range(0, 19) == 0)
				src_count = src_count + $urandom;
			else
				src_count = src_count + $urandom_range(0, 2 * count_span) - count_span;
		end
		p.record_present = ($urandom_range(0, 99) >= 3);
		p.latest_present = ($urandom_range(0, 99) >= 4);
		p.sample_sequence = src_seq;
		p.record_epoch = src_rec_ep;
		p.source_restart_epoch = src_src_ep;
		p.source_health = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) :
			eac_pkg::ST_VALID;
		p.now_ms = src_now;
		p.payload_ok = ($urandom_range(0, 49) != 0);
		p.raw_count = src_count;
		return p;
	endfunction

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	// Check every result transaction against the oldest prediction.
	always @(posedge clk) begin
		eac_pkg::out_item_t want;
		eac_pkg::out_item_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (poll_results_q.size() == 0) begin
				mismatches++;
				$display("%0t: result expected none actual %h", $time, got);
			end else begin
				want = poll_results_q.pop_front();
				compare_field("poll_state", 64'(want.poll_state), 64'(got.poll_state));
				compare_field("diag_code", 64'(want.diag_code), 64'(got.diag_code));
				compare_field("published", 64'(want.published), 64'(got.published));
				compare_field("angle", want.angle, got.angle);
				compare_field("discontinuity_count", 64'(want.discontinuity_count),
					64'(got.discontinuity_count));
				compare_field("out_sequence", want.out_sequence, got.out_sequence);
				compare_field("out_epoch", 64'(want.out_epoch), 64'(got.out_epoch));
			end
		end
	end

	// Classification without any sample seen, under the reset settings.
	task automatic test_classify_basics();
		send_poll(make_poll_item(1'b0, 1'b1, 64'd9, 32'd1, 32'd1, eac_pkg::ST_VALID,
			32'd5, 1'b1, 32'd0));
		send_poll(make_poll_item(1'b1, 1'b0, 64'd9, 32'd1, 32'd1, eac_pkg::ST_NO_DATA,
			32'd6, 1'b1, 32'd0));
		// Sequence and epoch equal to the reset values do not count as a new sample.
		send_poll(make_poll_item(1'b1, 1'b1, 64'd0, 32'd0, 32'd3, eac_pkg::ST_VALID,
			32'd900, 1'b1, 32'd0));
		send_poll(make_poll_item(1'b1, 1'b1, 64'd0, 32'd0, 32'd0, eac_pkg::ST_UNAVAIL,
			32'd901, 1'b1, 32'd0));
		send_poll(make_poll_item(1'b1, 1'b0, 64'd0, 32'd0, 32'd0, eac_pkg::ST_FAULT,
			32'd902, 1'b0, 32'd0));
		drain_results();
	endtask

	// Samples, quiet polls, stale timeout, missing payload, restarts and wrapping.
	task automatic test_sample_tracking();
		load_settings(32'd100, 32'h1000_0000);
		send_poll(make_poll_item(1'b1, 1'b1, 64'd1, 32'd5, 32'd7, eac_pkg::ST_NO_DATA,
			32'd1000, 1'b1, 32'd100));
		send_poll(make_poll_item(1'b1, 1'b1, 64'd2, 32'd5, 32'd7, eac_pkg::ST_VALID,
			32'd1010, 1'b1, 32'd110));
		send_poll(make_poll_item(1'b1, 1'b1, 64'd2, 32'd5, 32'd7, eac_pkg::ST_VALID,
			32'd1110, 1'b1, 32'd999));
		send_poll(make_poll_item(1'b1, 1'b1, 64'd2, 32'd5, 32'd7, eac_pkg::ST_VALID,
			32'd1111, 1'b1, 32'd999));
		send_poll(make_poll_item(1'b1, 1'b1, 64'd3, 32'd5, 32'd7, eac_pkg::ST_VALID,
			32'd1120, 1'b0, 32'd500));
		send_poll(make_poll_item(1'b1, 1'b1, 64'd4, 32'd5, 32'd8, eac_pkg::ST_VALID,
			32'd1130, 1'b1, 32'd600));
		send_poll(make_poll_item(1'b1, 1'b1, 64'd4, 32'd6, 32'd8, eac_pkg::ST_VALID,
			32'd1140, 1'b1, 32'd700));
		// Count and time both wrap between the next two samples.
		send_poll(make_poll_item(1'b1, 1'b1, 64'd5, 32'd6, 32'd8, eac_pkg::ST_VALID,
			32'hFFFF_FFF0, 1'b1, 32'h7FFF_FFF0));
		send_poll(make_poll_item(1'b1, 1'b1, 64'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			eac_pkg::ST_VALID, 32'h0000_0010, 1'b1, 32'h8000_0010));
		send_poll(make_poll_item(1'b1, 1'b1, 64'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			eac_pkg::ST_FAULT, 32'h0001_0000, 1'b1, 32'd0));
		send_poll(make_poll_item(1'b1, 1'b1, 64'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			eac_pkg::ST_VALID, 32'h0000_0075, 1'b1, 32'd0));
		drain_results();
	endtask

	// Largest steps in both directions drive the angle into both limits.
	task automatic test_angle_saturation();
		logic [31:0] count;
		logic [63:0] seq;
		count = 32'd0;
		seq = 64'hFFFF_FFFF_FFFF_FFF0;
		load_settings(32'd0, 32'h7FFF_FFFF);
		repeat (5) begin
			seq = seq + 64'd1;
			count = count + 32'h7FFF_FFFF;
			send_poll(make_poll_item(1'b1, 1'b1, seq, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
				eac_pkg::ST_VALID, $urandom, 1'b1, count));
		end
		drain_results();
		load_settings(32'h8000_0000, 32'h8000_0000);
		repeat (5) begin
			seq = seq + 64'd1;
			count = count + 32'h7FFF_FFFF;
			send_poll(make_poll_item(1'b1, 1'b1, seq, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
				eac_pkg::ST_VALID, $urandom, 1'b1, count));
		end
		drain_results();
	endtask

	// Receiver holds off while polls keep coming, then the sender waits for all results.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		src_seq = 64'd1000;
		src_rec_ep = $urandom;
		src_src_ep = $urandom;
		src_now = $urandom;
		src_count = $urandom;
		count_span = 500;
		load_settings(32'd250, 32'h0010_0000);
		@(posedge clk);
		hold_request = 60;
		@(negedge clk);
		repeat (16)
			send_poll(next_random_poll());
		drain_results();
		repeat (16)
			send_poll(next_random_poll());
		drain_results();
	endtask

	// Random traffic under several settings and idle mixes.
	task automatic test_random_traffic();
		logic [31:0] stale_word;
		logic [31:0] step_word;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin stale_word = 32'd250;        step_word = 32'h1000_0000; end
				1: begin stale_word = 32'd0;          step_word = 32'h7FFF_FFFF; end
				2: begin stale_word = 32'h7FFF_FFFF;  step_word = 32'h8000_0000; end
				3: begin stale_word = 32'd1;          step_word = 32'hFFFF_FFFF; end
				4: begin stale_word = $urandom;       step_word = $urandom;      end
				5: begin stale_word = 32'd50;         step_word = 32'h0000_0001; end
				6: begin stale_word = 32'h8000_00FA;  step_word = 32'h0000_0000; end
				default: begin stale_word = $urandom_range(0, 400); step_word = $urandom; end
			endcase
			count_span = (ph % 3 == 1) ? 32'h4000_0000 : $urandom_range(1, 5000);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			load_settings(stale_word, step_word);
			repeat (210)
				send_poll(next_random_poll());
			drain_results();
		end
	endtask

	// Run limit, far beyond the slowest correct run.
	initial begin
		#1000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = eac_pkg::CFG_STALE_LIMIT;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_classify_basics();
		test_sample_tracking();
		test_angle_saturation();
		test_backpressure();
		test_random_traffic();
		// Leave room for any stray result to show up.
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
